FILE: design/mtspc_pkg.sv
// ----------------------------------------------------------------------------
// Tile and sprite compositor package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package mtspc_pkg;

  localparam int SpriteEntries = 40;
  localparam int LineWidth     = 160;
  localparam int VisibleLines  = 144;
  localparam int SmemSize      = 160;

  typedef enum logic [1:0] {
    MODE_VWRITE = 2'd0,
    MODE_SWRITE = 2'd1,
    MODE_RENDER = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_LCDC = 3'd0, REG_SCY = 3'd1, REG_SCX = 3'd2, REG_WY = 3'd3,
    REG_WX = 3'd4, REG_BGP = 3'd5, REG_OBPA = 3'd6, REG_OBPB = 3'd7
  } reg_index_t;

  localparam logic [12:0] MapLow     = 13'h1800;
  localparam logic [12:0] MapHigh    = 13'h1C00;
  localparam logic [12:0] SignedBase = 13'h0800;

  typedef struct packed {
    logic [7:0] lcdc;
    logic [7:0] scy;
    logic [7:0] scx;
    logic [7:0] wy;
    logic [7:0] wx;
    logic [7:0] bgp;
    logic [7:0] obpa;
    logic [7:0] obpb;
  } regs_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BG_MAP, ST_BG_LO, ST_BG_HI, ST_BG_PIX,
    ST_WIN_MAP, ST_WIN_LO, ST_WIN_HI, ST_WIN_PIX,
    ST_SPR_Y, ST_SPR_X, ST_SPR_T, ST_SPR_A, ST_SPR_LO, ST_SPR_HI, ST_OUT
  } state_t;

  function automatic logic [1:0] pal_lookup(input logic [7:0] pal, input logic [1:0] c);
    logic [1:0] r;
    unique case (c)
      2'd0: r = pal[1:0];
      2'd1: r = pal[3:2];
      2'd2: r = pal[5:4];
      default: r = pal[7:6];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] shade_level(input logic [1:0] s);
    logic [7:0] r;
    unique case (s)
      2'd0: r = 8'h00;
      2'd1: r = 8'h54;
      2'd2: r = 8'hAA;
      default: r = 8'hFF;
    endcase
    return r;
  endfunction

endpackage

FILE: design/mono_tile_sprite_pixel_compositor_core.sv
// ----------------------------------------------------------------------------
// Monochrome tile and sprite pixel compositor
// Renders one pixel per render beat from video and sprite memory.
// ----------------------------------------------------------------------------
// Usage: input beats arrive on s_axis; tdata carries mode, address,
// write_data, line and column. Write beats (video or sprite memory) are
// registered and written from idle, hold off the next beat until then and
// produce no output beat. A render beat walks a sequencer that reads the
// single video memory port and the single sprite memory port one byte per
// cycle: map, low and high pattern reads for the background and again for
// the window, then four attribute reads for each of the 40 sprites plus two
// pattern reads for each sprite that covers the pixel, then the output
// state. The sprite reads happen only with sprites on (LCDC bit 1), and the
// scan over the one sprite memory port takes the longest. The result is
// held in an output register on m_axis, which parts the two sides: write
// beats and a new render are taken while it waits, and a render only stalls
// in its output state until the previous result has gone. Render beats
// outside the screen give no result. Configuration writes on the cfg
// channel are always taken. Reset clears the registers to their reset
// values and the sequencer to idle; memory contents are undefined until
// written.
// ----------------------------------------------------------------------------
module mono_tile_sprite_pixel_compositor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[1:0], address[14:2], write_data[22:15], line[30:23], column[38:31]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_shade[1:0], shade_level[9:2], raw_bg_colour[11:10]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mtspc_pkg::*;

  regs_t       regs;
  state_t      state, state_next;
  logic [1:0]  mode;
  logic [12:0] in_addr;
  logic [7:0]  in_data, line, column;
  logic [5:0]  spr;
  logic [7:0]  sy, sx, tidx, attr, lo_byte, tile_idx;
  logic [1:0]  raw, shade;
  logic        vwe, owe;
  logic [12:0] vaddr;
  logic [7:0]  oaddr, vrd, ord;
  logic        wrpend;
  logic        out_free;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{lcdc: 8'h00, scy: 8'h00, scx: 8'h00, wy: 8'h00, wx: 8'h00,
                bgp: 8'hE4, obpa: 8'hE4, obpb: 8'hE4};
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_LCDC: regs.lcdc <= cfg_data;
        REG_SCY:  regs.scy  <= cfg_data;
        REG_SCX:  regs.scx  <= cfg_data;
        REG_WY:   regs.wy   <= cfg_data;
        REG_WX:   regs.wx   <= cfg_data;
        REG_BGP:  regs.bgp  <= cfg_data;
        REG_OBPA: regs.obpa <= cfg_data;
        default:  regs.obpb <= cfg_data;
      endcase
    end
  end

  // Map and pixel coordinates for the fetch in progress.
  logic [7:0] bx, by, wxp, wyp;
  logic       win_on, spr_hit;
  logic [8:0] sline, scol, height;
  logic [3:0] srow;
  logic [2:0] sbit, bbit, wbit;
  logic [12:0] map_entry_bg, map_entry_win, tile_base;
  assign bx  = column + regs.scx;
  assign by  = line + regs.scy;
  assign wxp = column + 8'd7 - regs.wx;
  assign wyp = line - regs.wy;
  assign win_on = regs.lcdc[5] && (line >= regs.wy) && (regs.wx >= 8'd7) &&
                  (regs.wx <= 8'd166) && ({1'b0, column} + 9'd7 >= {1'b0, regs.wx});
  assign bbit = 3'd7 - bx[2:0];
  assign wbit = 3'd7 - wxp[2:0];
  assign map_entry_bg  = (regs.lcdc[3] ? MapHigh : MapLow) + {3'd0, by[7:3], bx[7:3]};
  assign map_entry_win = (regs.lcdc[6] ? MapHigh : MapLow) + {3'd0, wyp[7:3], wxp[7:3]};
  // The map byte arrives in the LO states and is used straight away for the
  // low pattern read; it is kept in tile_idx for the high pattern read.
  logic [2:0] trow;
  logic [7:0] tile_sel;
  assign trow = (state == ST_BG_LO || state == ST_BG_HI) ? by[2:0] : wyp[2:0];
  assign tile_sel = (state == ST_BG_LO || state == ST_WIN_LO) ? vrd : tile_idx;
  assign tile_base = regs.lcdc[4] ? {1'b0, tile_sel, 4'd0}
                   : SignedBase + {1'b0, tile_sel ^ 8'h80, 4'd0};

  // Sprite hit test: line + 16 in [sy, sy+height), column + 8 in [sx, sx+8).
  // The attribute byte arrives in SPR_A, where the pattern address is formed.
  logic [7:0] sattr;
  assign sattr  = (state == ST_SPR_A) ? ord : attr;
  assign height = regs.lcdc[2] ? 9'd16 : 9'd8;
  assign sline  = {1'b0, line} + 9'd16 - {1'b0, sy};
  assign scol   = {1'b0, column} + 9'd8 - {1'b0, sx};
  assign spr_hit = ({1'b0, line} + 9'd16 >= {1'b0, sy}) && (sline < height) &&
                   ({1'b0, column} + 9'd8 >= {1'b0, sx}) && (scol < 9'd8);
  assign srow = sattr[6] ? (height[3:0] - 4'd1 - sline[3:0]) : sline[3:0];
  assign sbit = attr[5] ? scol[2:0] : 3'd7 - scol[2:0];
  logic [12:0] spr_row;
  logic [7:0]  sidx;
  assign sidx    = regs.lcdc[2] ? (tidx & 8'hFE) : tidx;
  assign spr_row = {1'b0, sidx, 4'd0} + {8'd0, srow, 1'b0};

  logic [2:0] cur_bit;
  assign cur_bit = (state == ST_BG_PIX) ? bbit : (state == ST_WIN_PIX) ? wbit : sbit;
  logic [1:0] pix;
  assign pix = {vrd[cur_bit], lo_byte[cur_bit]};

  logic accept_in;
  assign s_axis_tready = (state == ST_IDLE) && !wrpend;
  assign accept_in = s_axis_tvalid && s_axis_tready;
  // The output register can take a new result when it is empty or being read.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_in && mode_t'(s_axis_tdata[1:0]) == MODE_RENDER &&
            s_axis_tdata[30:23] < 8'(VisibleLines) &&
            s_axis_tdata[38:31] < 8'(LineWidth)) begin
          state_next = ST_BG_MAP;
        end
      end
      ST_BG_MAP:  state_next = ST_BG_LO;
      ST_BG_LO:   state_next = ST_BG_HI;
      ST_BG_HI:   state_next = ST_BG_PIX;
      ST_BG_PIX:  state_next = ST_WIN_MAP;
      ST_WIN_MAP: state_next = ST_WIN_LO;
      ST_WIN_LO:  state_next = ST_WIN_HI;
      ST_WIN_HI:  state_next = ST_WIN_PIX;
      ST_WIN_PIX: state_next = regs.lcdc[1] ? ST_SPR_Y : ST_OUT;
      ST_SPR_Y:   state_next = ST_SPR_X;
      ST_SPR_X:   state_next = ST_SPR_T;
      ST_SPR_T:   state_next = ST_SPR_A;
      ST_SPR_A:   state_next = spr_hit ? ST_SPR_LO :
                               (spr == 6'(SpriteEntries - 1)) ? ST_OUT : ST_SPR_Y;
      ST_SPR_LO:  state_next = ST_SPR_HI;
      ST_SPR_HI:  state_next = (spr == 6'(SpriteEntries - 1)) ? ST_OUT : ST_SPR_Y;
      ST_OUT:     state_next = out_free ? ST_IDLE : ST_OUT;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Memory addressing; the read issued in a state returns in the next one.
  always_comb begin
    vwe = 1'b0;
    owe = 1'b0;
    vaddr = in_addr;
    oaddr = {spr, 2'd0};
    unique case (state)
      ST_IDLE: begin
        vwe = wrpend && mode == MODE_VWRITE;
        owe = wrpend && mode == MODE_SWRITE && in_addr < 13'(SmemSize);
        oaddr = in_addr[7:0];
        vaddr = wrpend ? in_addr : map_entry_bg;
      end
      ST_BG_MAP:  vaddr = map_entry_bg;
      ST_BG_LO, ST_WIN_LO: vaddr = tile_base + {9'd0, trow, 1'b0};
      ST_BG_HI, ST_WIN_HI: vaddr = tile_base + {9'd0, trow, 1'b0} + 13'd1;
      ST_WIN_MAP: vaddr = map_entry_win;
      ST_SPR_Y:   oaddr = {spr, 2'd1};
      ST_SPR_X:   oaddr = {spr, 2'd2};
      ST_SPR_T:   oaddr = {spr, 2'd3};
      ST_SPR_A: begin
        vaddr = spr_row;
        oaddr = {spr + 6'd1, 2'd0};
      end
      ST_SPR_LO:  vaddr = spr_row + 13'd1;
      ST_SPR_HI:  oaddr = {spr + 6'd1, 2'd0};
      default: ;
    endcase
  end

  mtspc_vram u_vram (.clk, .we(vwe), .addr(vaddr), .wdata(in_data), .rdata(vrd));
  mtspc_oam  u_oam  (.clk, .we(owe), .addr(oaddr), .wdata(in_data), .rdata(ord));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wrpend <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      wrpend <= accept_in && (mode_t'(s_axis_tdata[1:0]) == MODE_VWRITE ||
                              mode_t'(s_axis_tdata[1:0]) == MODE_SWRITE);
      if (state == ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      mode    <= s_axis_tdata[1:0];
      in_addr <= s_axis_tdata[14:2];
      in_data <= s_axis_tdata[22:15];
      line    <= s_axis_tdata[30:23];
      column  <= s_axis_tdata[38:31];
      raw     <= 2'd0;
      shade   <= 2'd0;
    end
    // Tile index in the LO states, low pattern byte in the HI states and in SPR_LO.
    unique case (state)
      ST_BG_LO, ST_WIN_LO: tile_idx <= vrd;
      ST_BG_HI, ST_WIN_HI, ST_SPR_LO: lo_byte <= vrd;
      default: ;
    endcase
    // The high pattern byte arrives in the PIX states.
    if (state == ST_BG_PIX && regs.lcdc[0]) begin
      raw   <= pix;
      shade <= pal_lookup(regs.bgp, pix);
    end
    if (state == ST_WIN_PIX && win_on) begin
      raw   <= pix;
      shade <= pal_lookup(regs.bgp, pix);
    end
    if (state == ST_BG_MAP || state == ST_WIN_MAP) spr <= 6'd0;
    if (state == ST_SPR_Y) sy <= ord;
    if (state == ST_SPR_X) sx <= ord;
    if (state == ST_SPR_T) tidx <= ord;
    if (state == ST_SPR_A) begin
      attr <= ord;
      if (!spr_hit) spr <= spr + 6'd1;
    end
    if (state == ST_SPR_HI) begin
      spr <= spr + 6'd1;
      if (pix != 2'd0 && (!attr[7] || raw == 2'd0)) begin
        shade <= pal_lookup(attr[4] ? regs.obpb : regs.obpa, pix);
      end
    end
    if (state == ST_OUT && out_free) begin
      m_axis_tdata <= {4'd0, raw, shade_level(shade), shade};
    end
  end
endmodule

FILE: design/mtspc_vram.sv
// ----------------------------------------------------------------------------
// Video memory
// 8 KiB single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mtspc_vram (
  input  logic        clk,
  input  logic        we,
  input  logic [12:0] addr,
  input  logic [7:0]  wdata,
  output logic [7:0]  rdata
);
  logic [7:0] mem [8192];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: design/mtspc_oam.sv
// ----------------------------------------------------------------------------
// Sprite attribute memory
// 160-byte single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mtspc_oam (
  input  logic       clk,
  input  logic       we,
  input  logic [7:0] addr,
  input  logic [7:0] wdata,
  output logic [7:0] rdata
);
  import mtspc_pkg::*;
  logic [7:0] mem [SmemSize];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
